FILE: sv/lss_pkg.sv
// ============================================================================
// lss_pkg: shared types and constants of the laser scan segmenter
// Holds register indexes, field widths, the queue item type, the
// configuration bundles and the arctangent table of the CORDIC unit.
// ============================================================================
`default_nettype none

package lss_pkg;

  localparam int MIN_POINTS = 6;
  localparam int MAX_BEAMS  = 4096;
  localparam int BEAM_W     = $clog2(MAX_BEAMS);

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int POSE_W  = 24;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W = 13;
  localparam int LOC_W   = 17;
  localparam int TRIG_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE    = 3'd0,
    REG_MAX_RANGE    = 3'd1,
    REG_GAP_LIMIT    = 3'd2,
    REG_START_ANGLE  = 3'd3,
    REG_ANGLE_STEP   = 3'd4,
    REG_POSE_X       = 3'd5,
    REG_POSE_Y       = 3'd6,
    REG_POSE_HEADING = 3'd7
  } lss_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               keep;
    logic               last;
    logic [ANGLE_W-1:0] angle;
  } lss_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range;
    logic [RANGE_W-1:0] max_range;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] angle_step;
  } lss_front_cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0]       gap_limit;
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
    logic [ANGLE_W-1:0]       pose_heading;
  } lss_back_cfg_t;

  function automatic logic signed [TRIG_W-1:0] atan_entry(input logic [3:0] i);
    logic signed [TRIG_W-1:0] v;
    unique case (i)
      4'd0:  v = 32'sd536870912;
      4'd1:  v = 32'sd316933406;
      4'd2:  v = 32'sd167458907;
      4'd3:  v = 32'sd85004757;
      4'd4:  v = 32'sd42667331;
      4'd5:  v = 32'sd21354465;
      4'd6:  v = 32'sd10679838;
      4'd7:  v = 32'sd5340245;
      4'd8:  v = 32'sd2670163;
      4'd9:  v = 32'sd1335087;
      4'd10: v = 32'sd667544;
      4'd11: v = 32'sd333772;
      4'd12: v = 32'sd166886;
      4'd13: v = 32'sd83443;
      4'd14: v = 32'sd41722;
      default: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lss_front.sv
// ============================================================================
// lss_front: beam counter and sample classifier
// Counts beams, forms the beam angle and applies the range window, then
// pushes one item per accepted transaction into the queue.
// ============================================================================
`default_nettype none

module lss_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  lss_pkg::lss_front_cfg_t  cfg,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire [lss_pkg::RANGE_W-1:0] in_range_mm,
  input  wire                      in_range_valid,
  input  wire                      in_scan_last,
  input  wire                      q_full,
  output logic                     q_push,
  output lss_pkg::lss_item_t       q_item
);
  import lss_pkg::*;

  logic [BEAM_W-1:0] beam_index_r;
  logic [BEAM_W-1:0] beam_index_nxt;
  logic [BEAM_W+ANGLE_W-1:0] step_prod;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign step_prod = {{ANGLE_W{1'b0}}, beam_index_r} * {{BEAM_W{1'b0}}, cfg.angle_step};

  always_comb begin
    q_item.range_mm = in_range_mm;
    q_item.keep     = in_range_valid && (in_range_mm >= cfg.min_range)
                      && (in_range_mm <= cfg.max_range);
    q_item.last     = in_scan_last;
    q_item.angle    = cfg.start_angle + step_prod[ANGLE_W-1:0];
    beam_index_nxt  = in_scan_last ? '0 : beam_index_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_index_r <= '0;
    end else if (q_push) begin
      beam_index_r <= beam_index_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lss_queue.sv
// ============================================================================
// lss_queue: two-entry item queue
// Decouples the classifier from the geometry engine.
// ============================================================================
`default_nettype none

module lss_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  lss_pkg::lss_item_t push_item,
  input  wire                pop,
  output logic               full,
  output logic               not_empty,
  output lss_pkg::lss_item_t head
);
  import lss_pkg::*;

  lss_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: sv/lss_cordic.sv
// ============================================================================
// lss_cordic: iterative sine and cosine
// Reduces the angle to the nearest quarter turn, runs sixteen rotation
// steps one per cycle and restores the quadrant. Results are Q30.
// ============================================================================
`default_nettype none

module lss_cordic (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire [lss_pkg::ANGLE_W-1:0]        angle,
  output logic                              done,
  output logic signed [lss_pkg::TRIG_W-1:0] cos_q30,
  output logic signed [lss_pkg::TRIG_W-1:0] sin_q30
);
  import lss_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIX} cstate_t;

  cstate_t                  state_r;
  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic [3:0]               iter_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [TRIG_W-1:0] dx, dy;
  logic [ANGLE_W:0]         quad_sum;
  logic [1:0]               quad;
  logic [ANGLE_W-1:0]       resid;

  always_comb begin
    quad_sum = {1'b0, angle} + 17'h02000;
    quad     = quad_sum[ANGLE_W-1:ANGLE_W-2];
    resid    = angle - {quad, 14'b0};
    dx       = y_r >>> iter_r;
    dy       = x_r >>> iter_r;
    if (!z_r[TRIG_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_entry(iter_r);
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_entry(iter_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
      cos_q30 <= '0;
      sin_q30 <= '0;
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      iter_r  <= '0;
      quad_r  <= '0;
    end else begin
      done <= (state_r == C_FIX);
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r     <= CORDIC_K;
            y_r     <= '0;
            z_r     <= {resid, 16'b0};
            quad_r  <= quad;
            iter_r  <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          iter_r <= iter_r + 1'b1;
          if (iter_r == 4'd15) begin
            state_r <= C_FIX;
          end
        end
        C_FIX: begin
          unique case (quad_r)
            2'd1: begin
              cos_q30 <= -y_r;
              sin_q30 <= x_r;
            end
            2'd2: begin
              cos_q30 <= -x_r;
              sin_q30 <= -y_r;
            end
            2'd3: begin
              cos_q30 <= y_r;
              sin_q30 <= -x_r;
            end
            default: begin
              cos_q30 <= x_r;
              sin_q30 <= y_r;
            end
          endcase
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/lss_back.sv
// ============================================================================
// lss_back: segmentation engine
// Turns kept samples into local points, runs the gap test, tracks the open
// segment and transforms closed segments into world coordinates. One shared
// multiplier carries every product. Results leave through an output register.
// ============================================================================
`default_nettype none

module lss_back (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lss_pkg::lss_back_cfg_t            cfg,
  input  wire                               q_not_empty,
  input  lss_pkg::lss_item_t                q_head,
  output logic                              q_pop,
  output logic                              cord_start,
  output logic [lss_pkg::ANGLE_W-1:0]       cord_angle,
  input  wire                               cord_done,
  input  wire signed [lss_pkg::TRIG_W-1:0]  cord_cos,
  input  wire signed [lss_pkg::TRIG_W-1:0]  cord_sin,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [lss_pkg::POSE_W-1:0] out_start_x,
  output logic signed [lss_pkg::POSE_W-1:0] out_start_y,
  output logic signed [lss_pkg::POSE_W-1:0] out_end_x,
  output logic signed [lss_pkg::POSE_W-1:0] out_end_y,
  output logic [lss_pkg::COUNT_W-1:0]       out_point_count,
  output logic                              out_segment_present,
  output logic                              out_scan_end
);
  import lss_pkg::*;

  localparam int PROD_W = 50;
  localparam int ACC_W  = 51;

  typedef enum logic [3:0] {
    S_IDLE, S_PCORD, S_PC, S_PS, S_PY, S_DX2, S_DY2, S_UPD,
    S_DEC, S_WCORD, S_WMUL, S_OUT
  } bstate_t;

  bstate_t                  state_r;
  logic [RANGE_W-1:0]       range_r;
  logic                     last_r;
  logic                     in_seg_r;
  logic signed [LOC_W-1:0]  sx_r, sy_r, lx_r, ly_r;
  logic [COUNT_W-1:0]       cnt_r;
  logic signed [LOC_W-1:0]  px_r, py_r;
  logic                     close_r;
  logic signed [LOC_W-1:0]  csx_r, csy_r, cex_r, cey_r;
  logic [COUNT_W-1:0]       ccnt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [3:0]               mstep_r;
  logic signed [POSE_W-1:0] world_r [4];

  logic signed [17:0]       mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [17:0]       dx, dy;
  logic signed [LOC_W-1:0]  round_loc;
  logic [2:0]               wj;
  logic signed [ACC_W-1:0]  wsum;
  logic signed [POSE_W-1:0] wval;
  logic [COUNT_W-1:0]       cnt_inc;
  logic                     gap_ok;

  function automatic logic signed [LOC_W-1:0] to_local(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic signed [19:0]       s;
    r = p + (PROD_W'(1) <<< 29);
    s = r[49:30];
    if (s < -20'sd65536) begin
      return -17'sd65536;
    end else if (s > 20'sd65535) begin
      return 17'sd65535;
    end
    return s[LOC_W-1:0];
  endfunction

  function automatic logic signed [POSE_W-1:0] to_world(input logic signed [ACC_W-1:0] v,
                                                        input logic signed [POSE_W-1:0] pose);
    logic signed [ACC_W-1:0] r;
    logic signed [24:0]      s;
    r = v + (ACC_W'(1) <<< 29);
    s = 25'(signed'(r[50:30])) + 25'(pose);
    if (s < -25'sd8388608) begin
      return -24'sd8388608;
    end else if (s > 25'sd8388607) begin
      return 24'sd8388607;
    end
    return s[POSE_W-1:0];
  endfunction

  assign q_pop   = (state_r == S_IDLE) && q_not_empty;
  assign dx      = 18'(px_r) - 18'(lx_r);
  assign dy      = 18'(py_r) - 18'(ly_r);
  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign gap_ok  = (acc_r <= ACC_W'(prod_r));
  assign wj      = 3'(mstep_r - 4'd1);
  assign round_loc = to_local(prod_r);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PC: begin
        mul_a = {2'b00, range_r};
        mul_b = cord_cos;
      end
      S_PS: begin
        mul_a = {2'b00, range_r};
        mul_b = cord_sin;
      end
      S_PY: begin
        mul_a = dx;
        mul_b = TRIG_W'(dx);
      end
      S_DX2: begin
        mul_a = dy;
        mul_b = TRIG_W'(dy);
      end
      S_DY2: begin
        mul_a = {2'b00, cfg.gap_limit};
        mul_b = TRIG_W'(mul_a);
      end
      S_WMUL: begin
        if (mstep_r[2]) begin
          mul_a = mstep_r[0] ? 18'(cey_r) : 18'(cex_r);
        end else begin
          mul_a = mstep_r[0] ? 18'(csy_r) : 18'(csx_r);
        end
        mul_b = (mstep_r[1:0] == 2'd0 || mstep_r[1:0] == 2'd3) ? cord_cos : cord_sin;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // World accumulation: odd products finish a coordinate.
  always_comb begin
    if (wj[1]) begin
      wsum = acc_r + ACC_W'(prod_r);
    end else begin
      wsum = acc_r - ACC_W'(prod_r);
    end
    wval = to_world(wsum, wj[1] ? cfg.pose_y : cfg.pose_x);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_seg_r   <= 1'b0;
      sx_r       <= '0;
      sy_r       <= '0;
      lx_r       <= '0;
      ly_r       <= '0;
      cnt_r      <= '0;
      close_r    <= 1'b0;
      cord_start <= 1'b0;
      cord_angle <= '0;
      out_valid  <= 1'b0;
      mstep_r    <= '0;
    end else begin
      cord_start <= ((state_r == S_IDLE) && q_not_empty && q_head.keep) ||
                    ((state_r == S_DEC) && close_r);
      if (out_valid && !out_stall && (state_r != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            range_r <= q_head.range_mm;
            last_r  <= q_head.last;
            if (q_head.keep) begin
              cord_angle <= q_head.angle;
              state_r    <= S_PCORD;
            end else begin
              close_r  <= in_seg_r && (cnt_r >= COUNT_W'(MIN_POINTS));
              csx_r    <= sx_r;
              csy_r    <= sy_r;
              cex_r    <= lx_r;
              cey_r    <= ly_r;
              ccnt_r   <= cnt_r;
              in_seg_r <= 1'b0;
              state_r  <= S_DEC;
            end
          end
        end
        S_PCORD: begin
          if (cord_done) begin
            state_r <= S_PC;
          end
        end
        S_PC: state_r <= S_PS;
        S_PS: begin
          px_r    <= round_loc;
          state_r <= S_PY;
        end
        S_PY: begin
          py_r    <= round_loc;
          state_r <= S_DX2;
        end
        S_DX2: begin
          acc_r   <= ACC_W'(prod_r);
          state_r <= S_DY2;
        end
        S_DY2: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          lx_r <= px_r;
          ly_r <= py_r;
          if (in_seg_r && gap_ok) begin
            cnt_r   <= cnt_inc;
            close_r <= last_r && (cnt_inc >= COUNT_W'(MIN_POINTS));
            csx_r   <= sx_r;
            csy_r   <= sy_r;
            cex_r   <= px_r;
            cey_r   <= py_r;
            ccnt_r  <= cnt_inc;
          end else begin
            close_r <= in_seg_r ? (cnt_r >= COUNT_W'(MIN_POINTS))
                                : (last_r && (MIN_POINTS <= 1));
            csx_r   <= in_seg_r ? sx_r : px_r;
            csy_r   <= in_seg_r ? sy_r : py_r;
            cex_r   <= in_seg_r ? lx_r : px_r;
            cey_r   <= in_seg_r ? ly_r : py_r;
            ccnt_r  <= in_seg_r ? cnt_r : COUNT_W'(1);
            sx_r    <= px_r;
            sy_r    <= py_r;
            cnt_r   <= COUNT_W'(1);
          end
          in_seg_r <= !last_r;
          state_r  <= S_DEC;
        end
        S_DEC: begin
          if (close_r) begin
            cord_angle <= cfg.pose_heading;
            state_r    <= S_WCORD;
          end else if (last_r) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_WCORD: begin
          mstep_r <= '0;
          if (cord_done) begin
            state_r <= S_WMUL;
          end
        end
        S_WMUL: begin
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r != 4'd0) begin
            if (!wj[0]) begin
              acc_r <= ACC_W'(prod_r);
            end else begin
              world_r[wj[2:1]] <= wval;
            end
          end
          if (mstep_r == 4'd8) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_segment_present <= close_r;
            out_scan_end        <= last_r;
            out_point_count     <= close_r ? ccnt_r : '0;
            out_start_x         <= close_r ? world_r[0] : '0;
            out_start_y         <= close_r ? world_r[1] : '0;
            out_end_x           <= close_r ? world_r[2] : '0;
            out_end_y           <= close_r ? world_r[3] : '0;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/laser_scan_segmenter.sv
// ============================================================================
// laser_scan_segmenter: breakpoint segmentation of laser range scans
// Top level: configuration registers, classifier, queue, CORDIC and engine.
// ============================================================================
// One range sample enters per input transaction. The block counts beams
// (the final beam of a scan resets the count), forms the beam angle as
// start_angle plus index times angle_step, keeps samples that are valid and
// inside [min_range, max_range], converts kept samples to local points and
// chains points whose squared distance stays within gap_limit squared. A run
// of at least MIN_POINTS beams is reported as one output transaction holding
// its first and last points in world coordinates (rotated by pose_heading,
// shifted by pose_x/pose_y, saturated to 24 bits). The final beam always
// yields one transaction with out_scan_end set; segment_present tells whether
// it carries a segment. A kept sample waits in the engine for the CORDIC unit
// (sixteen rotations plus start and quadrant fix-up) that gives the beam's
// sine and cosine; a rejected one skips it. Closing a segment adds a second
// CORDIC run on the heading, the eight products on the shared multiplier and
// the output register; a final beam that closes nothing goes straight to the
// output register. The output register waits while an earlier result is
// stalled. A two-entry queue lets the input side take samples while the
// engine works, and the output register holds a result while the next sample
// is processed. Configuration is written through cfg_we/cfg_index/cfg_data
// while idle; the block itself does no check of this.
// ============================================================================
`default_nettype none

module laser_scan_segmenter (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [lss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [lss_pkg::CFG_W-1:0]           cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [lss_pkg::RANGE_W-1:0]         in_range_mm,
  input  wire                                in_range_valid,
  input  wire                                in_scan_last,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [lss_pkg::POSE_W-1:0]  out_start_x,
  output logic signed [lss_pkg::POSE_W-1:0]  out_start_y,
  output logic signed [lss_pkg::POSE_W-1:0]  out_end_x,
  output logic signed [lss_pkg::POSE_W-1:0]  out_end_y,
  output logic [lss_pkg::COUNT_W-1:0]        out_point_count,
  output logic                               out_segment_present,
  output logic                               out_scan_end
);
  import lss_pkg::*;

  lss_front_cfg_t front_cfg_r;
  lss_back_cfg_t  back_cfg_r;

  logic                     q_full, q_push, q_pop, q_not_empty;
  lss_item_t                q_in, q_head;
  logic                     cord_start, cord_done;
  logic [ANGLE_W-1:0]       cord_angle;
  logic signed [TRIG_W-1:0] cord_cos, cord_sin;

  // Configuration registers; user writes only while block is idle; no check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cfg_r.min_range   <= 16'd400;
      front_cfg_r.max_range   <= 16'd600;
      front_cfg_r.start_angle <= 16'd0;
      front_cfg_r.angle_step  <= 16'd64;
      back_cfg_r.gap_limit    <= 16'd150;
      back_cfg_r.pose_x       <= '0;
      back_cfg_r.pose_y       <= '0;
      back_cfg_r.pose_heading <= '0;
    end else if (cfg_we) begin
      unique case (lss_reg_t'(cfg_index))
        REG_MIN_RANGE:    front_cfg_r.min_range   <= cfg_data[RANGE_W-1:0];
        REG_MAX_RANGE:    front_cfg_r.max_range   <= cfg_data[RANGE_W-1:0];
        REG_GAP_LIMIT:    back_cfg_r.gap_limit    <= cfg_data[RANGE_W-1:0];
        REG_START_ANGLE:  front_cfg_r.start_angle <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_STEP:   front_cfg_r.angle_step  <= cfg_data[ANGLE_W-1:0];
        REG_POSE_X:       back_cfg_r.pose_x       <= cfg_data;
        REG_POSE_Y:       back_cfg_r.pose_y       <= cfg_data;
        REG_POSE_HEADING: back_cfg_r.pose_heading <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  lss_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (front_cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_mm    (in_range_mm),
    .in_range_valid (in_range_valid),
    .in_scan_last   (in_scan_last),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  lss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lss_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start),
    .angle   (cord_angle),
    .done    (cord_done),
    .cos_q30 (cord_cos),
    .sin_q30 (cord_sin)
  );

  lss_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (back_cfg_r),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .cord_start          (cord_start),
    .cord_angle          (cord_angle),
    .cord_done           (cord_done),
    .cord_cos            (cord_cos),
    .cord_sin            (cord_sin),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_start_x         (out_start_x),
    .out_start_y         (out_start_y),
    .out_end_x           (out_end_x),
    .out_end_y           (out_end_y),
    .out_point_count     (out_point_count),
    .out_segment_present (out_segment_present),
    .out_scan_end        (out_scan_end)
  );

endmodule

`default_nettype wire
